### hdl/u2a_pkg.sv
// Shared types and constants for the unsigned-to-ASCII radix converter.
// Depends on nothing; used by every module in hdl/.
package u2a_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int VALUE_W        = 32;
	localparam int BASE_W         = 5;
	localparam int CHAR_W         = 7;
	localparam int COUNT_W        = 6;
	localparam int DIGIT_W        = 4;
	localparam int STEP_BITS      = 8;   // quotient bits resolved per divide cycle

	localparam logic [BASE_W-1:0]  BASE_MIN  = 5'd2;
	localparam logic [BASE_W-1:0]  BASE_MAX  = 5'd16;
	localparam logic [DIGIT_W-1:0] DIGIT_TEN = 4'd10;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0]  CHAR_A    = 7'h61;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [BASE_W-1:0]  base;
	} req_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0]  character;
		logic               is_last;
		logic [COUNT_W-1:0] digit_count;
	} chr_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic pop;
	} dp_cmd_t;

	typedef struct packed {
		logic digit_done;
		logic quo_zero;
		logic last_digit;
	} dp_status_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d >= DIGIT_TEN) begin
			c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
		end else begin
			c = CHAR_ZERO + CHAR_W'(d);
		end
		return c;
	endfunction

endpackage

### hdl/u2a_ctrl.sv
// Sequencer for the converter: load, divide digit by digit, then emit.
// Depends on u2a_pkg; drives the datapath through dp_cmd_t.
module u2a_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	output logic                chr_valid,
	input  logic                chr_stall,
	output u2a_pkg::dp_cmd_t    cmd,
	input  u2a_pkg::dp_status_t status
);
	import u2a_pkg::*;

	state_t state_q, state_nxt;
	logic   chr_valid_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_nxt = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (status.digit_done && status.quo_zero) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (cmd.pop && status.last_digit) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				cmd.load  = req_valid;
			end
			ST_DIVIDE: begin
				cmd.step = 1'b1;
			end
			ST_EMIT: begin
				// refill the output register when it is empty or being taken
				cmd.pop = !chr_valid_q || !chr_stall;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			chr_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.pop) begin
				chr_valid_q <= 1'b1;
			end else if (!chr_stall) begin
				chr_valid_q <= 1'b0;
			end
		end
	end

	assign chr_valid = chr_valid_q;

endmodule

### hdl/u2a_dpath.sv
// Datapath: shift-subtract divider, digit stack and output register.
// Depends on u2a_pkg; commanded by u2a_ctrl.
module u2a_dpath #(
	parameter int VALUE_BITS = u2a_pkg::VALUE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  u2a_pkg::req_item_t  req,
	input  u2a_pkg::dp_cmd_t    cmd,
	output u2a_pkg::dp_status_t status,
	output u2a_pkg::chr_item_t  chr
);
	import u2a_pkg::*;

	localparam int NUM_W = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
	localparam int STEPS = (NUM_W + STEP_BITS - 1) / STEP_BITS;
	localparam int DIV_W = STEPS * STEP_BITS;
	localparam int BC_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int DEPTH = NUM_W;   // base 2 gives one digit per bit
	localparam logic [BC_W-1:0] BC_LAST = BC_W'(STEPS - 1);

	logic [DIV_W-1:0]   work_q, work_nxt;
	logic [DIGIT_W-1:0] rem_q;
	logic [DIGIT_W:0]   rem_nxt;
	logic [BASE_W-1:0]  base_q, base_clamp;
	logic [BC_W-1:0]    bcnt_q;
	logic [COUNT_W-1:0] count_q, depth_q;
	logic [DIGIT_W-1:0] stack_q [DEPTH];
	chr_item_t          chr_q;
	logic               digit_done;

	always_comb begin
		if (req.base < BASE_MIN) begin
			base_clamp = BASE_MIN;
		end else if (req.base > BASE_MAX) begin
			base_clamp = BASE_MAX;
		end else begin
			base_clamp = req.base;
		end
	end

	// STEP_BITS restoring division steps on a narrow remainder
	always_comb begin
		logic [DIV_W-1:0] w;
		logic [DIGIT_W:0] r;
		w = work_q;
		r = {1'b0, rem_q};
		for (int i = 0; i < STEP_BITS; i++) begin
			r = {r[DIGIT_W-1:0], w[DIV_W-1]};
			w = {w[DIV_W-2:0], 1'b0};
			if (r >= base_q) begin
				r    = r - base_q;
				w[0] = 1'b1;
			end
		end
		work_nxt = w;
		rem_nxt  = r;
	end

	assign digit_done        = cmd.step && (bcnt_q == BC_LAST);
	assign status.digit_done = digit_done;
	assign status.quo_zero   = (work_nxt == '0);
	assign status.last_digit = (depth_q == COUNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q  <= '0;
			count_q <= '0;
			depth_q <= '0;
		end else begin
			if (cmd.load) begin
				bcnt_q  <= '0;
				count_q <= '0;
				depth_q <= '0;
			end else if (digit_done) begin
				bcnt_q  <= '0;
				count_q <= count_q + COUNT_W'(1);
				depth_q <= depth_q + COUNT_W'(1);
			end else if (cmd.step) begin
				bcnt_q <= bcnt_q + BC_W'(1);
			end else if (cmd.pop) begin
				depth_q <= depth_q - COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			work_q <= DIV_W'(req.value[NUM_W-1:0]);
			rem_q  <= '0;
			base_q <= base_clamp;
		end else if (digit_done) begin
			work_q <= work_nxt;
			rem_q  <= '0;
		end else if (cmd.step) begin
			work_q <= work_nxt;
			rem_q  <= rem_nxt[DIGIT_W-1:0];
		end
	end

	// digits come out least significant first; the stack reverses them
	always_ff @(posedge clk) begin
		if (digit_done) begin
			stack_q[0] <= rem_nxt[DIGIT_W-1:0];
			for (int i = 1; i < DEPTH; i++) begin
				stack_q[i] <= stack_q[i-1];
			end
		end else if (cmd.pop) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				stack_q[i] <= stack_q[i+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			chr_q.character   <= digit_char(stack_q[0]);
			chr_q.is_last     <= status.last_digit;
			chr_q.digit_count <= count_q;
		end
	end

	assign chr = chr_q;

endmodule

### hdl/unsigned_to_ascii_radix_core.sv
// Channel | Dir | Handshake             | Payload
// req     | in  | req_valid / req_stall | value, base  (req_item_t)
// chr     | out | chr_valid / chr_stall | character, is_last, digit_count  (chr_item_t)
//
// Each request is loaded, divided digit by digit by the 8-bit-per-cycle shift-subtract divider,
// then emitted most significant digit first.
// One request is in work at a time; the next is taken while the last character waits.
// arst_n clears the sequencer and the output valid; payload registers are not reset.
// A stalled chr channel holds its character and pauses the emit phase.
// Depends on u2a_pkg, u2a_ctrl and u2a_dpath.
module unsigned_to_ascii_radix_core #(
	parameter int VALUE_BITS = u2a_pkg::VALUE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  u2a_pkg::req_item_t req,
	output logic               chr_valid,
	input  logic               chr_stall,
	output u2a_pkg::chr_item_t chr
);
	import u2a_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	u2a_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.chr_valid (chr_valid),
		.chr_stall (chr_stall),
		.cmd       (cmd),
		.status    (status)
	);

	u2a_dpath #(
		.VALUE_BITS (VALUE_BITS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.status (status),
		.chr    (chr)
	);

endmodule

### verif/tb_top.sv
// Self-checking bench for unsigned_to_ascii_radix_core: directed table then random requests.
// Predicts the digit stream per request and checks every character in order.
// Depends on hdl/u2a_pkg.sv and the core RTL.
`timescale 1ns / 100ps

module tb_top;
	import u2a_pkg::*;

	localparam int  VB          = VALUE_BITS_DEF;
	localparam int  MAX_CHARS   = 32;
	localparam int  RAND_ITEMS  = 300;
	localparam int  CYCLE_LIMIT = 900_000;
	localparam int  TAIL_CYCLES = 200;
	localparam logic [VALUE_W-1:0] VALUE_MASK =
		(VB >= VALUE_W) ? {VALUE_W{1'b1}} : ((VALUE_W'(1) << VB) - VALUE_W'(1));

	// text holds the expected digits right-justified; zero means use the predictor
	typedef struct packed {
		logic [VALUE_W-1:0]     value;
		logic [BASE_W-1:0]      base;
		logic [MAX_CHARS*8-1:0] text;
	} dir_row_t;

	localparam int N_DIR = 24;
	localparam dir_row_t DIR_ROWS [0:N_DIR-1] = '{
		'{32'd0,          5'd10, "0"},
		'{32'd0,          5'd0,  "0"},
		'{32'd0,          5'd31, "0"},
		'{32'hFFFF_FFFF,  5'd16, "ffffffff"},
		'{32'hFFFF_FFFF,  5'd17, "ffffffff"},
		'{32'hFFFF_FFFF,  5'd31, "ffffffff"},
		'{32'hFFFF_FFFF,  5'd2,  "11111111111111111111111111111111"},
		'{32'hFFFF_FFFF,  5'd1,  "11111111111111111111111111111111"},
		'{32'hFFFF_FFFF,  5'd0,  "11111111111111111111111111111111"},
		'{32'hFFFF_FFFF,  5'd10, "4294967295"},
		'{32'hDEAD_BEEF,  5'd16, "deadbeef"},
		'{32'd1,          5'd2,  "1"},
		'{32'd9,          5'd10, "9"},
		'{32'd10,         5'd10, "10"},
		'{32'd10,         5'd16, "a"},
		'{32'd15,         5'd16, "f"},
		'{32'd16,         5'd16, "10"},
		'{32'h8000_0000,  5'd2,  256'd0},
		'{32'hFFFF_FFFF,  5'd3,  256'd0},
		'{32'hFFFF_FFFF,  5'd7,  256'd0},
		'{32'hFFFF_FFFF,  5'd11, 256'd0},
		'{32'hFFFF_FFFF,  5'd15, 256'd0},
		'{32'h0012_3456,  5'd13, 256'd0},
		'{32'hA5A5_5A5A,  5'd5,  256'd0}
	};

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req       = '0;
	logic      chr_valid;
	logic      chr_stall = 1'b0;
	chr_item_t chr;

	chr_item_t exp_chars [$];
	int        err_count     = 0;
	int        cycle_cnt     = 0;
	int        send_idle_pct = 0;
	int        stall_pct     = 0;

	unsigned_to_ascii_radix_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.chr_valid (chr_valid),
		.chr_stall (chr_stall),
		.chr       (chr)
	);

	always #10 clk = ~clk;

	task automatic note_mismatch(input string what);
		err_count++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	// digits least significant first, then queued most significant first
	function automatic void predict_chars(input req_item_t item);
		logic [VALUE_W-1:0] num;
		logic [VALUE_W-1:0] radix;
		logic [VALUE_W-1:0] d;
		logic [CHAR_W-1:0]  rev [MAX_CHARS];
		chr_item_t          c;
		int                 n;
		num = item.value & VALUE_MASK;
		radix = VALUE_W'(item.base);
		if (item.base < BASE_MIN)
			radix = VALUE_W'(BASE_MIN);
		else if (item.base > BASE_MAX)
			radix = VALUE_W'(BASE_MAX);
		n = 0;
		if (num == 0) begin
			rev[0] = CHAR_ZERO;
			n = 1;
		end else begin
			while (num != 0 && n < MAX_CHARS) begin
				d = num % radix;
				if (d >= VALUE_W'(DIGIT_TEN))
					rev[n] = CHAR_A + CHAR_W'(d - VALUE_W'(DIGIT_TEN));
				else
					rev[n] = CHAR_ZERO + CHAR_W'(d);
				num = num / radix;
				n++;
			end
		end
		for (int k = 0; k < n; k++) begin
			c.character   = rev[n-1-k];
			c.is_last     = (k == n - 1);
			c.digit_count = COUNT_W'(n);
			exp_chars.push_back(c);
		end
	endfunction

	function automatic void queue_typed(input logic [MAX_CHARS*8-1:0] text);
		chr_item_t c;
		int        len;
		len = 0;
		while (len < MAX_CHARS && text[len*8 +: 8] != 8'd0)
			len++;
		for (int k = 0; k < len; k++) begin
			c.character   = CHAR_W'(text[(len-1-k)*8 +: 8]);
			c.is_last     = (k == len - 1);
			c.digit_count = COUNT_W'(len);
			exp_chars.push_back(c);
		end
	endfunction

	function automatic req_item_t rand_req();
		req_item_t r;
		int        sel;
		sel = $urandom_range(99);
		if (sel < 35)
			r.value = $urandom;
		else if (sel < 55)
			r.value = $urandom_range(0, 255);
		else if (sel < 75)
			r.value = $urandom >> $urandom_range(31);
		else if (sel < 82)
			r.value = '0;
		else
			r.value = {VALUE_W{1'b1}} >> $urandom_range(31);
		if ($urandom_range(99) < 85)
			r.base = BASE_W'($urandom_range(2, 16));
		else
			r.base = BASE_W'($urandom_range(0, 31));
		return r;
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_req(input req_item_t item, input logic [MAX_CHARS*8-1:0] text);
		if ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(negedge clk);
		end
		req       <= item;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (req_stall);
		if (text != '0)
			queue_typed(text);
		else
			predict_chars(item);
		@(negedge clk);
	endtask

	always @(negedge clk)
		chr_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin : chr_monitor
		chr_item_t want;
		if (arst_n && chr_valid && !chr_stall) begin
			if (exp_chars.size() == 0) begin
				note_mismatch($sformatf("unexpected character %h", chr.character));
			end else begin
				want = exp_chars.pop_front();
				if (chr.character !== want.character)
					note_mismatch($sformatf("character %h, want %h",
						chr.character, want.character));
				if (chr.is_last !== want.is_last)
					note_mismatch($sformatf("is_last %b, want %b",
						chr.is_last, want.is_last));
				if (chr.digit_count !== want.digit_count)
					note_mismatch($sformatf("digit_count %0d, want %0d",
						chr.digit_count, want.digit_count));
			end
		end
	end

	initial begin : watchdog
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : main_seq
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIR; i++)
			send_req(req_item_t'{value: DIR_ROWS[i].value, base: DIR_ROWS[i].base},
				DIR_ROWS[i].text);

		for (int i = 0; i < RAND_ITEMS; i++) begin
			case (i / (RAND_ITEMS / 4))
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 64; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 64; end
				default: begin send_idle_pct = 15; stall_pct = 15; end
			endcase
			send_req(rand_req(), '0);
		end
		req_valid <= 1'b0;

		while (exp_chars.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
